// ===== hw/rtl/fps_pkg.sv =====
`default_nettype none

package fps_pkg;

  // Coordinate and distance widths are fixed by the point format.
  localparam int CoordBits = 8;
  localparam int PointBits = 2 * CoordBits;
  localparam int DistBits  = 2 * CoordBits + 1;

  // Configuration register indexes.
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 10;
  localparam logic [CfgIdxBits-1:0] CfgSelectCount = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgFirstPick   = 1'd1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [DistBits-1:0]  dist_t;

  // Sequencer states.
  localparam int StBits = 3;
  localparam logic [StBits-1:0] StIdle  = 3'd0;
  localparam logic [StBits-1:0] StStart = 3'd1;
  localparam logic [StBits-1:0] StFetch = 3'd2;
  localparam logic [StBits-1:0] StEmit  = 3'd3;
  localparam logic [StBits-1:0] StScan  = 3'd4;
  localparam logic [StBits-1:0] StDrain = 3'd5;

endpackage

`default_nettype wire

// ===== hw/rtl/farthest_point_sampler.sv =====
// Greedy farthest-point sampler for a set of 2-D points.
//
// Loading: one point word is taken per cycle on start/busy (accepted when
// start is high and busy is low). Words without last_point only store the
// point, and busy stays low, so points can stream at one per cycle.
// A word with last_point stores its point and starts selection; busy then
// stays high until the run is over.
// Selection: the first pick is the point at first_pick (clamped to the
// loaded set). Every further pick needs one pass over all N loaded points
// through a five-stage distance pipeline, one datapath reused for every
// point and pick, so busy stays high for a run of K picks until the final
// pick is shown, with one pass over the distance memory per further pick.
// Results: each pick is shown on pick_x_o/pick_y_o for one cycle with
// pick_valid_o high; last_pick_o marks the final one. The receiver cannot
// stall, so results are never held back. A zero select count gives no word.
// Configuration writes (select count, first pick) are taken any cycle the
// write enable is high and are meant for idle periods only.
// Reset empties the point set, sets the select count to 15 and the first
// pick to 0; the point and distance memories need no clearing.
`default_nettype none

module farthest_point_sampler #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_SELECT = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire  fps_pkg::coord_t         point_x_i,
  input  wire  fps_pkg::coord_t         point_y_i,
  input  wire                           last_point_i,
  input  wire                           cfg_we_i,
  input  wire  [fps_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire  [fps_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output logic                          pick_valid_o,
  output fps_pkg::coord_t               pick_x_o,
  output fps_pkg::coord_t               pick_y_o,
  output logic                          last_pick_o
);
  import fps_pkg::*;

  localparam int IdxW = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int SelW = $clog2(MAX_SELECT + 1);
  localparam int EntW = DistBits + 1;
  localparam int SqW  = 2 * CoordBits;

  // Configuration registers.
  logic [4:0]              cfg_sel_q;
  logic [CfgDataBits-1:0]  cfg_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sel_q   <= 5'd15;
      cfg_first_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSelectCount: cfg_sel_q   <= cfg_wdata_i[4:0];
        CfgFirstPick:   cfg_first_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Memories: packed points and {taken, nearest distance} per point.
  logic [PointBits-1:0] pt_mem [MAX_POINTS];
  logic [EntW-1:0]      nd_mem [MAX_POINTS];

  logic [StBits-1:0] state_q;
  logic [CntW-1:0]   count_q, scan_q;
  logic [SelW-1:0]   target_q, picks_q;
  logic [IdxW-1:0]   pick_idx_q, best_idx_q;
  dist_t             best_d_q;
  logic              found_q, first_pass_q, busy_q;
  logic [PointBits-1:0] pick_xy_q;

  logic              accept, store_pt, issue;
  logic [CntW-1:0]   new_count;
  logic [SelW-1:0]   sel_sat, target_d;
  logic [IdxW-1:0]   first_d, rd_addr;

  logic [PointBits-1:0] pt_rd_q;
  logic [EntW-1:0]      nd_rd_q;

  // Distance pipeline registers.
  logic            vb_q, vc_q, vd_q, ve_q;
  logic [IdxW-1:0] idx_b_q, idx_c_q, idx_d_q, idx_e_q;
  coord_t          dx_c_q, dy_c_q, dy_d_q;
  logic [EntW-1:0] nd_c_q, nd_d_q, nd_e_q;
  logic [SqW-1:0]  sqx_d_q;
  dist_t           dist_e_q;

  coord_t          dx_b, dy_b;
  dist_t           old_d, upd_d;
  logic            upd_taken, cand;

  assign accept    = start && !busy_q;
  assign store_pt  = accept && (32'(count_q) < MAX_POINTS);
  assign new_count = store_pt ? count_q + 1'b1 : count_q;
  assign issue     = (state_q == StScan) && (scan_q < count_q);
  assign busy      = busy_q;

  always_comb begin
    if (32'(cfg_sel_q) > MAX_SELECT) sel_sat = SelW'(MAX_SELECT);
    else                             sel_sat = SelW'(cfg_sel_q);
    if (32'(sel_sat) > 32'(new_count)) target_d = SelW'(new_count);
    else                               target_d = sel_sat;
    if (32'(cfg_first_q) < 32'(new_count)) first_d = IdxW'(cfg_first_q);
    else                                   first_d = IdxW'(new_count - 1'b1);
  end

  assign rd_addr = (state_q == StFetch) ? pick_idx_q : scan_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (store_pt) begin
      pt_mem[count_q[IdxW-1:0]] <= {point_x_i, point_y_i};
    end
    pt_rd_q <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ve_q) begin
      nd_mem[idx_e_q] <= {upd_taken, upd_d};
    end
    nd_rd_q <= nd_mem[scan_q[IdxW-1:0]];
  end

  // Stage b: absolute coordinate differences against the current pick.
  always_comb begin
    coord_t px, py, qx, qy;
    px = pick_xy_q[PointBits-1:CoordBits];
    py = pick_xy_q[CoordBits-1:0];
    qx = pt_rd_q[PointBits-1:CoordBits];
    qy = pt_rd_q[CoordBits-1:0];
    dx_b = (qx > px) ? qx - px : px - qx;
    dy_b = (qy > py) ? qy - py : py - qy;
  end

  // Stage e: keep the nearer distance (the new one on the first pass), mark the pick taken, track the best.
  assign old_d     = nd_e_q[DistBits-1:0];
  assign upd_d     = (first_pass_q || dist_e_q < old_d) ? dist_e_q : old_d;
  assign upd_taken = (!first_pass_q && nd_e_q[DistBits]) || (idx_e_q == pick_idx_q);
  assign cand      = ve_q && !upd_taken && (!found_q || upd_d > best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      vb_q <= issue;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_b_q  <= scan_q[IdxW-1:0];
    idx_c_q  <= idx_b_q;
    dx_c_q   <= dx_b;
    dy_c_q   <= dy_b;
    nd_c_q   <= nd_rd_q;
    idx_d_q  <= idx_c_q;
    sqx_d_q  <= SqW'(dx_c_q) * SqW'(dx_c_q);
    dy_d_q   <= dy_c_q;
    nd_d_q   <= nd_c_q;
    idx_e_q  <= idx_d_q;
    dist_e_q <= DistBits'(sqx_d_q) + DistBits'(SqW'(dy_d_q) * SqW'(dy_d_q));
    nd_e_q   <= nd_d_q;
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      busy_q       <= 1'b0;
      count_q      <= '0;
      scan_q       <= '0;
      target_q     <= '0;
      picks_q      <= '0;
      pick_idx_q   <= '0;
      best_idx_q   <= '0;
      best_d_q     <= '0;
      found_q      <= 1'b0;
      first_pass_q <= 1'b0;
      pick_valid_o <= 1'b0;
      last_pick_o  <= 1'b0;
    end else begin
      pick_valid_o <= 1'b0;
      last_pick_o  <= 1'b0;
      if (cand) begin
        found_q    <= 1'b1;
        best_idx_q <= idx_e_q;
        best_d_q   <= upd_d;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            count_q <= new_count;
            if (last_point_i) begin
              target_q   <= target_d;
              pick_idx_q <= first_d;
              busy_q     <= 1'b1;
              state_q    <= StStart;
            end
          end
        end
        StStart: begin
          picks_q      <= '0;
          first_pass_q <= 1'b1;
          if (target_q == '0) begin
            count_q <= '0;
            busy_q  <= 1'b0;
            state_q <= StIdle;
          end else begin
            state_q <= StFetch;
          end
        end
        StFetch: state_q <= StEmit;
        StEmit: begin
          pick_valid_o <= 1'b1;
          picks_q      <= picks_q + 1'b1;
          if (picks_q + 1'b1 == target_q) begin
            last_pick_o <= 1'b1;
            count_q     <= '0;
            busy_q      <= 1'b0;
            state_q     <= StIdle;
          end else begin
            scan_q  <= '0;
            found_q <= 1'b0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (issue) scan_q <= scan_q + 1'b1;
          else       state_q <= StDrain;
        end
        StDrain: begin
          // Leave once the last point has gone through the update stage.
          if (!(vb_q || vc_q || vd_q || ve_q)) begin
            pick_idx_q   <= best_idx_q;
            first_pass_q <= 1'b0;
            state_q      <= StFetch;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Output payload registers are written only with a word.
  always_ff @(posedge clk_i) begin
    if (state_q == StEmit) begin
      pick_xy_q <= pt_rd_q;
      pick_x_o  <= pt_rd_q[PointBits-1:CoordBits];
      pick_y_o  <= pt_rd_q[CoordBits-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fps_checker.sv =====
`default_nettype none

module fps_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input wire       last_point_i,
  input wire       pick_valid_o,
  input wire       last_pick_o
);

  // A word that does not close the set never starts a run.
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_point_i) |=> !busy)
    else $error("busy rose after a plain load word");

  // Every pick but the final one is shown while the run is still going.
  a_mid_pick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pick_valid_o && !last_pick_o) |-> busy)
    else $error("pick word outside a run");

  // The final pick closes the run.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pick_valid_o && last_pick_o) |-> !busy)
    else $error("run still busy after final pick");

  // Each pick needs a memory fetch, so two words are never adjacent.
  a_no_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_valid_o |=> !pick_valid_o)
    else $error("pick words in adjacent cycles");

endmodule

bind farthest_point_sampler fps_checker u_fps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .last_point_i(last_point_i),
  .pick_valid_o(pick_valid_o),
  .last_pick_o (last_pick_o)
);

`default_nettype wire

// ===== verif/tb_farthest_point_sampler.sv =====
`default_nettype none

module tb_farthest_point_sampler;
  import fps_pkg::*;

  localparam int MaxPoints     = 1024;
  localparam int MaxSelect     = 16;
  localparam int WatchdogLimit = 10000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } point_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pick_word_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t point_x_i = '0;
  coord_t point_y_i = '0;
  logic last_point_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic pick_valid_o;
  coord_t pick_x_o;
  coord_t pick_y_o;
  logic last_pick_o;

  point_word_t point_words[$];
  point_word_t loaded_set[$];
  pick_word_t pending_picks[$];
  point_word_t cur_word;
  int unsigned words_left = 0;
  int unsigned idle_pct = 13;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  logic [4:0] select_count_r = 5'd15;
  logic [9:0] first_pick_r = 10'd0;

  farthest_point_sampler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .last_point_i(last_point_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pick_valid_o(pick_valid_o),
    .pick_x_o    (pick_x_o),
    .pick_y_o    (pick_y_o),
    .last_pick_o (last_pick_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Greedy farthest-point selection over the loaded set; appends one pick per
  // selected point to pending_picks.
  function automatic void select_farthest();
    int n, target, idx, best, best_d, picks, d, dx, dy;
    logic found;
    bit taken[];
    int nearest[];
    n = loaded_set.size();
    target = (select_count_r > MaxSelect) ? MaxSelect : int'(select_count_r);
    if (target > n) target = n;
    if (target == 0) return;
    taken = new[n];
    nearest = new[n];
    idx = (first_pick_r < n) ? int'(first_pick_r) : n - 1;
    picks = 0;
    while (1) begin
      taken[idx] = 1'b1;
      for (int i = 0; i < n; i++) begin
        dx = int'(loaded_set[i].x) - int'(loaded_set[idx].x);
        dy = int'(loaded_set[i].y) - int'(loaded_set[idx].y);
        d = dx * dx + dy * dy;
        if (picks == 0 || d < nearest[i]) nearest[i] = d;
      end
      pending_picks.insert(pending_picks.size(),
                           pick_word_t'{loaded_set[idx].x, loaded_set[idx].y, 1'b0});
      picks++;
      if (picks == target) break;
      found = 1'b0;
      best = 0;
      best_d = 0;
      for (int i = 0; i < n; i++) begin
        if (!taken[i] && (!found || nearest[i] > best_d)) begin
          found = 1'b1;
          best = i;
          best_d = nearest[i];
        end
      end
      idx = best;
    end
    pending_picks[pending_picks.size()-1].last = 1'b1;
  endfunction

  // Points past the store depth are dropped, but their last flag still counts.
  function automatic void load_point(point_word_t w);
    if (loaded_set.size() < MaxPoints) loaded_set.insert(loaded_set.size(), w);
    if (w.last) begin
      select_farthest();
      loaded_set.delete();
    end
  endfunction

  always @(posedge clk_i) begin : drive_points
    logic go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      go = start;
      if (start && !busy) begin
        load_point(cur_word);
        words_left--;
        go = 1'b0;
      end
      if (!go && point_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_word = point_words.pop_front();
        point_x_i <= cur_word.x;
        point_y_i <= cur_word.y;
        last_point_i <= cur_word.last;
        go = 1'b1;
      end
      start <= go;
    end
  end

  always @(posedge clk_i) begin : check_picks
    pick_word_t want;
    if (rst_ni && pick_valid_o) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected pick x=%0d y=%0d last=%0b", $time, pick_x_o, pick_y_o,
                 last_pick_o);
        error_count++;
      end else begin
        want = pending_picks.pop_front();
        if (pick_x_o !== want.x) begin
          $display("%0t: pick_x expected %0d, got %0d", $time, want.x, pick_x_o);
          error_count++;
        end
        if (pick_y_o !== want.y) begin
          $display("%0t: pick_y expected %0d, got %0d", $time, want.y, pick_y_o);
          error_count++;
        end
        if (last_pick_o !== want.last) begin
          $display("%0t: last_pick expected %0b, got %0b", $time, want.last, last_pick_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || pick_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_point(input coord_t x, input coord_t y, input logic last);
    point_words.insert(point_words.size(), point_word_t'{x, y, last});
    words_left++;
  endtask

  task automatic write_cfg(input logic [CfgIdxBits-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[CfgDataBits-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgSelectCount) begin
      select_count_r = val[4:0];
    end else begin
      first_pick_r = val[9:0];
    end
  endtask

  task automatic set_config(input int unsigned count, input int unsigned first);
    write_cfg(CfgSelectCount, count);
    write_cfg(CfgFirstPick, first);
  endtask

  // Waits until every word is sent and every pick seen, then lets the block
  // finish a run that may give no pick at all.
  task automatic settle();
    do @(posedge clk_i); while (words_left != 0 || pending_picks.size() != 0);
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic random_config();
    int unsigned count, first;
    case ($urandom_range(7))
      0: count = 0;
      1: count = MaxSelect;
      2: count = $urandom_range(31, MaxSelect + 1);
      default: count = $urandom_range(15, 1);
    endcase
    first = ($urandom_range(3) == 0) ? $urandom_range(1023, 0) : $urandom_range(7, 0);
    set_config(count, first);
  endtask

  task automatic push_random_set(output int size);
    logic narrow;
    size = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
    // Tiny coordinate ranges make duplicate points and distance ties likely.
    narrow = ($urandom_range(3) == 0);
    for (int i = 0; i < size; i++) begin
      if (narrow) begin
        push_point(coord_t'($urandom_range(3)), coord_t'($urandom_range(3)), i == size - 1);
      end else begin
        push_point(coord_t'($urandom_range(255)), coord_t'($urandom_range(255)),
                   i == size - 1);
      end
    end
  endtask

  initial begin : stimulus
    int sent, size;
    int unsigned idle_plan[3];
    idle_plan = '{13, 66, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: count 15, first pick at index 0.
    push_point(8'd0, 8'd0, 1'b0);
    push_point(8'd255, 8'd255, 1'b0);
    push_point(8'd255, 8'd0, 1'b1);
    settle();

    // A zero count gives no pick.
    set_config(0, 0);
    push_point(8'd17, 8'd200, 1'b0);
    push_point(8'd90, 8'd3, 1'b1);
    settle();

    // Count saturates and the set runs out; first pick is clamped.
    set_config(31, 1023);
    push_point(8'd7, 8'd7, 1'b0);
    push_point(8'd7, 8'd7, 1'b0);
    push_point(8'd200, 8'd9, 1'b0);
    push_point(8'd0, 8'd255, 1'b0);
    push_point(8'd255, 8'd0, 1'b1);
    settle();

    set_config(MaxSelect, 2);
    push_point(8'd128, 8'd127, 1'b1);
    settle();

    set_config(1, 0);
    push_point(8'd1, 8'd2, 1'b0);
    push_point(8'd250, 8'd251, 1'b0);
    push_point(8'd100, 8'd100, 1'b1);
    settle();

    // Equal distances around the first pick go to the earliest loaded.
    set_config(4, 0);
    push_point(8'd10, 8'd10, 1'b0);
    push_point(8'd20, 8'd10, 1'b0);
    push_point(8'd0, 8'd10, 1'b0);
    push_point(8'd10, 8'd20, 1'b0);
    push_point(8'd10, 8'd0, 1'b1);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = idle_plan[phase];
      for (int seg = 0; seg < 4; seg++) begin
        random_config();
        sent = 0;
        while (sent < 26) begin
          push_random_set(size);
          sent += size;
        end
        settle();
      end
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
